>>> design/wsdb_pkg.sv
// ----------------------------------------------------------------------------
// wsdb_pkg
// Shared types and constants for the work-stealing deque bank.
// ----------------------------------------------------------------------------
package wsdb_pkg;

   localparam int JOB_BITS    = 16;
   localparam int WORKER_BITS = 3;
   localparam int COUNT_BITS  = 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 4'd8;

   typedef enum logic [0:0] {
      ACT_PUSH = 1'b0,
      ACT_GET  = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_PUSHED = 3'd0,
      ST_FULL   = 3'd1,
      ST_OWN    = 3'd2,
      ST_STOLE  = 3'd3,
      ST_NONE   = 3'd4,
      ST_BAD    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OWN,
      S_SCAN,
      S_JOB,
      S_DONE
   } state_type;

endpackage

>>> design/wsdb_ram.sv
// ----------------------------------------------------------------------------
// wsdb_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wsdb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/work_stealing_deque_bank_core.sv
// ----------------------------------------------------------------------------
// work_stealing_deque_bank_core
// Bank of per-worker ring deques of job handles. Push appends at the
// worker's tail; get takes its own newest job or steals the oldest job of
// the first non-empty victim after it.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   req     | req_valid/req_stall, action, worker, job | in
//   rsp     | rsp_valid/rsp_stall, status, job, victim | out
//   csr     | psel/penable/pwrite/paddr/pwdata/prdata  | in/out
//
// One request at a time. A bad worker is answered without a RAM read; a push
// or own take reads its worker's pointer entry first; a steal or none result
// is set by the victim scan, one pointer RAM read per cycle.
// Synchronous reset clears the pointers through per-worker valid bits; the
// job RAM is not cleared.
// A stalled result sits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module work_stealing_deque_bank_core #(
   parameter int NUM_WORKERS = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int HANDLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [wsdb_pkg::WORKER_BITS-1:0]      req_worker,
   input  logic [wsdb_pkg::JOB_BITS-1:0]         req_job_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_status,
   output logic [wsdb_pkg::JOB_BITS-1:0]         rsp_job_out,
   output logic [wsdb_pkg::WORKER_BITS-1:0]      rsp_victim,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [wsdb_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [wsdb_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [wsdb_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);

   localparam int VW = $clog2(NUM_WORKERS);
   localparam int CW = ((VW > wsdb_pkg::COUNT_BITS) ? VW : wsdb_pkg::COUNT_BITS) + 1;
   localparam int PW = $clog2(2 * QUEUE_DEPTH);
   localparam int SW = $clog2(QUEUE_DEPTH);
   localparam int AW = $clog2(NUM_WORKERS * QUEUE_DEPTH);
   localparam int SB = (HANDLE_BITS < wsdb_pkg::JOB_BITS) ? HANDLE_BITS : wsdb_pkg::JOB_BITS;
   localparam int WB = wsdb_pkg::WORKER_BITS;

   function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
      slot_of = (p >= PW'(QUEUE_DEPTH)) ? SW'(p - PW'(QUEUE_DEPTH)) : SW'(p);
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] wi,
                                             input logic [SW-1:0] s);
      addr_of = AW'(wi) * AW'(QUEUE_DEPTH) + AW'(s);
   endfunction

   // state
   wsdb_pkg::state_type  state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [wsdb_pkg::COUNT_BITS-1:0] worker_count_ff, worker_count_in;
   logic [NUM_WORKERS-1:0] ptr_valid_ff, ptr_valid_in;
   logic                 ptr_ok_ff, ptr_ok_in;

   // payload
   wsdb_pkg::action_type action_ff, action_in;
   logic [CW-1:0]        worker_ff, worker_in;
   logic [SB-1:0]        hold_job_ff, hold_job_in;
   logic [CW-1:0]        ec_ff, ec_in;
   logic [CW-1:0]        vic_ff, vic_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   wsdb_pkg::status_type res_status_ff, res_status_in;
   logic [SB-1:0]        res_job_ff, res_job_in;
   logic [WB-1:0]        res_victim_ff, res_victim_in;
   wsdb_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SB-1:0]        rsp_job_ff, rsp_job_in;
   logic [WB-1:0]        rsp_victim_ff, rsp_victim_in;

   // memories
   logic                 ptr_wr_en, ptr_rd_en;
   logic [VW-1:0]        ptr_wr_addr, ptr_rd_addr;
   logic [2*PW-1:0]      ptr_wr_data, ptr_rd_data;
   logic                 job_wr_en, job_rd_en;
   logic [AW-1:0]        job_wr_addr, job_rd_addr;
   logic [SB-1:0]        job_wr_data, job_rd_data;

   logic [CW-1:0]        count_ext, ec_now, req_w_ext, w_next, v_next, cnt_next;
   logic [PW-1:0]        head_q, tail_q, tail_inc, tail_dec, head_inc;
   logic [PW:0]          occ;
   logic                 empty, full, out_free, load_out, cfg_wr;

   wsdb_ram #(.WIDTH(2 * PW), .DEPTH(NUM_WORKERS)) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr_en),
      .wr_addr (ptr_wr_addr),
      .wr_data (ptr_wr_data),
      .rd_en   (ptr_rd_en),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd_data)
   );

   wsdb_ram #(.WIDTH(SB), .DEPTH(NUM_WORKERS * QUEUE_DEPTH)) u_job_ram (
      .clock   (clock),
      .wr_en   (job_wr_en),
      .wr_addr (job_wr_addr),
      .wr_data (job_wr_data),
      .rd_en   (job_rd_en),
      .rd_addr (job_rd_addr),
      .rd_data (job_rd_data)
   );

   // configuration
   assign cfg_wr = psel && penable && pwrite && !paddr[2];
   assign worker_count_in = cfg_wr ? pwdata[wsdb_pkg::COUNT_BITS-1:0] : worker_count_ff;
   assign prdata = wsdb_pkg::CSR_DATA_BITS'(worker_count_ff);
   assign pready = 1'b1;

   // effective worker count: 0 acts as 1, clamp at NUM_WORKERS
   assign count_ext = CW'(worker_count_ff);
   assign ec_now = (count_ext == '0) ? CW'(1) :
                   (count_ext > CW'(NUM_WORKERS)) ? CW'(NUM_WORKERS) : count_ext;
   assign req_w_ext = CW'(req_worker);

   // pointer arithmetic on the entry just read
   assign head_q = ptr_ok_ff ? ptr_rd_data[2*PW-1:PW] : '0;
   assign tail_q = ptr_ok_ff ? ptr_rd_data[PW-1:0] : '0;
   assign occ = {1'b0, tail_q} - {1'b0, head_q} +
                ((tail_q < head_q) ? (PW+1)'(2 * QUEUE_DEPTH) : '0);
   assign empty = (tail_q == head_q);
   assign full = (occ >= (PW+1)'(QUEUE_DEPTH));
   assign tail_inc = (tail_q == PW'(2 * QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
   assign tail_dec = (tail_q == '0) ? PW'(2 * QUEUE_DEPTH - 1) : tail_q - 1'b1;
   assign head_inc = (head_q == PW'(2 * QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

   assign w_next = (worker_ff + 1'b1 == ec_ff) ? '0 : worker_ff + 1'b1;
   assign v_next = (vic_ff + 1'b1 == ec_ff) ? '0 : vic_ff + 1'b1;
   assign cnt_next = cnt_ff + 1'b1;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == wsdb_pkg::S_DONE) && out_free;
   assign rsp_valid_in = load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wsdb_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_w_ext >= ec_now) ? wsdb_pkg::S_DONE : wsdb_pkg::S_OWN;
            end
         end
         wsdb_pkg::S_OWN: begin
            if (action_ff == wsdb_pkg::ACT_PUSH) begin
               state_in = wsdb_pkg::S_DONE;
            end else if (!empty) begin
               state_in = wsdb_pkg::S_JOB;
            end else if (ec_ff == CW'(1)) begin
               state_in = wsdb_pkg::S_DONE;
            end else begin
               state_in = wsdb_pkg::S_SCAN;
            end
         end
         wsdb_pkg::S_SCAN: begin
            if (!empty) begin
               state_in = wsdb_pkg::S_JOB;
            end else if (cnt_next == ec_ff) begin
               state_in = wsdb_pkg::S_DONE;
            end
         end
         wsdb_pkg::S_JOB: begin
            state_in = wsdb_pkg::S_DONE;
         end
         wsdb_pkg::S_DONE: begin
            if (out_free) begin
               state_in = wsdb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wsdb_pkg::S_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      action_in     = action_ff;
      worker_in     = worker_ff;
      hold_job_in   = hold_job_ff;
      ec_in         = ec_ff;
      vic_in        = vic_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_job_in    = res_job_ff;
      res_victim_in = res_victim_ff;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_victim_in = rsp_victim_ff;
      ptr_wr_en     = 1'b0;
      ptr_wr_addr   = worker_ff[VW-1:0];
      ptr_wr_data   = {head_q, tail_q};
      ptr_rd_en     = 1'b0;
      ptr_rd_addr   = worker_ff[VW-1:0];
      job_wr_en     = 1'b0;
      job_wr_addr   = addr_of(worker_ff, slot_of(tail_q));
      job_wr_data   = hold_job_ff;
      job_rd_en     = 1'b0;
      job_rd_addr   = addr_of(worker_ff, slot_of(tail_dec));
      req_stall     = (state_ff != wsdb_pkg::S_IDLE);
      case (state_ff)
         wsdb_pkg::S_IDLE: begin
            if (req_valid) begin
               action_in     = wsdb_pkg::action_type'(req_action);
               worker_in     = req_w_ext;
               hold_job_in   = req_job_in[SB-1:0];
               ec_in         = ec_now;
               res_job_in    = '0;
               res_victim_in = req_worker;
               if (req_w_ext >= ec_now) begin
                  res_status_in = wsdb_pkg::ST_BAD;
                  res_victim_in = '0;
               end else begin
                  ptr_rd_en   = 1'b1;
                  ptr_rd_addr = req_w_ext[VW-1:0];
               end
            end
         end
         wsdb_pkg::S_OWN: begin
            if (action_ff == wsdb_pkg::ACT_PUSH) begin
               if (full) begin
                  res_status_in = wsdb_pkg::ST_FULL;
               end else begin
                  res_status_in = wsdb_pkg::ST_PUSHED;
                  job_wr_en     = 1'b1;
                  ptr_wr_en     = 1'b1;
                  ptr_wr_data   = {head_q, tail_inc};
               end
            end else if (!empty) begin
               res_status_in = wsdb_pkg::ST_OWN;
               ptr_wr_en     = 1'b1;
               ptr_wr_data   = {head_q, tail_dec};
               job_rd_en     = 1'b1;
            end else begin
               res_status_in = wsdb_pkg::ST_NONE;
               if (ec_ff != CW'(1)) begin
                  vic_in      = w_next;
                  cnt_in      = CW'(1);
                  ptr_rd_en   = 1'b1;
                  ptr_rd_addr = w_next[VW-1:0];
               end
            end
         end
         wsdb_pkg::S_SCAN: begin
            if (!empty) begin
               res_status_in = wsdb_pkg::ST_STOLE;
               res_victim_in = vic_ff[WB-1:0];
               ptr_wr_en     = 1'b1;
               ptr_wr_addr   = vic_ff[VW-1:0];
               ptr_wr_data   = {head_inc, tail_q};
               job_rd_en     = 1'b1;
               job_rd_addr   = addr_of(vic_ff, slot_of(head_q));
            end else if (cnt_next != ec_ff) begin
               vic_in      = v_next;
               cnt_in      = cnt_next;
               ptr_rd_en   = 1'b1;
               ptr_rd_addr = v_next[VW-1:0];
            end
         end
         wsdb_pkg::S_JOB: begin
            res_job_in = job_rd_data;
         end
         wsdb_pkg::S_DONE: begin
            if (out_free) begin
               rsp_status_in = res_status_ff;
               rsp_job_in    = res_job_ff;
               rsp_victim_in = res_victim_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // pointer entries never written read as zero
   always_comb begin
      ptr_valid_in = ptr_valid_ff;
      if (ptr_wr_en) begin
         ptr_valid_in[ptr_wr_addr] = 1'b1;
      end
   end
   assign ptr_ok_in = ptr_rd_en ? ptr_valid_ff[ptr_rd_addr] : ptr_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= wsdb_pkg::S_IDLE;
         rsp_valid_ff    <= 1'b0;
         worker_count_ff <= wsdb_pkg::COUNT_RESET;
         ptr_valid_ff    <= '0;
         ptr_ok_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         worker_count_ff <= worker_count_in;
         ptr_valid_ff    <= ptr_valid_in;
         ptr_ok_ff       <= ptr_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      worker_ff     <= worker_in;
      hold_job_ff   <= hold_job_in;
      ec_ff         <= ec_in;
      vic_ff        <= vic_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_job_ff    <= res_job_in;
      res_victim_ff <= res_victim_in;
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_job_out = wsdb_pkg::JOB_BITS'(rsp_job_ff);
   assign rsp_victim  = rsp_victim_ff;

endmodule
